>>> design/lbs_pkg.sv
// Shared types and constants for the linear blend skinning engine.
// Depends on nothing; the engine top and the testbench refer to it by scoped names.
package lbs_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

  localparam int unsigned ELEMS       = 12;
  localparam int unsigned ROWS        = 3;
  localparam int unsigned COLS        = 3;
  localparam int unsigned ID_W        = 6;
  localparam int unsigned WGT_W       = 16;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned SLOT_BONE_W = 7;
  localparam int unsigned ROW_W       = 50;
  localparam int unsigned TERM_W      = 52;
  localparam int unsigned ACC_W       = 54;

  // Division of a palette slot by 12 as multiply by 683 and shift by 13.
  localparam int unsigned DIV12_MUL   = 683;
  localparam int unsigned DIV12_SHIFT = 13;

  typedef struct packed {
    logic        first;
    logic        last;
    logic        single;
    logic [15:0] index;
    logic [15:0] weight;
  } lbs_tag_t;

endpackage

>>> design/lbs_if.sv
// Valid/ready channel interfaces for the skinning engine input and result words.
// Depends on nothing; the top level takes one of each.
interface lbs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [9:0]  matrix_slot;
  logic signed [31:0] matrix_value;
  logic [15:0] vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [1:0]  influence_count;
  logic [23:0] bone_ids;
  logic [63:0] bone_weights;

  modport source (output valid, cmd, matrix_slot, matrix_value, vertex_index, pos_x,
                  pos_y, pos_z, influence_count, bone_ids, bone_weights, input ready);
  modport sink (input valid, cmd, matrix_slot, matrix_value, vertex_index, pos_x,
                pos_y, pos_z, influence_count, bone_ids, bone_weights, output ready);
endinterface

interface lbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_index;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        saturated;

  modport source (output valid, out_index, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_index, out_x, out_y, out_z, saturated, output ready);
endinterface

>>> design/linear_blend_skinning.sv
// Linear blend skinning engine: bone palette memory, read sequencer and datapath.
// Depends on lbs_pkg and on the channel interfaces in lbs_if.
//
// Usage: words arrive on in_ch. A load word (cmd 0) writes one palette element in the
// cycle it is accepted and returns nothing; a slot at or above BONES*12 is dropped.
// A skin word (cmd 1) returns one result word on out_ch with the weighted sum of
// its one to four bone transforms applied to the position; a lone bone goes unweighted.
// Throughput: a skin word holds the palette port while its bones are read, one bone's
// full 3x4 matrix per cycle unless out_ch stalls; a load word uses only the write side.
// The next word is accepted in the cycle the last bone of the current vertex is read.
// Pipeline: the last bone read passes the memory read register, products, row sums and
// weighted terms, and is then accumulated into the output register.
// Reset clears the sequencer, all pipeline valids and the output valid; the palette keeps
// whatever it held and must be loaded before a bone is used.
// When out_ch stalls with a result waiting, the whole pipeline and the memory read
// register hold, and in_ch drops ready until the result is taken.
module linear_blend_skinning #(
  parameter int unsigned BONES = 64
) (
  input  logic clk,
  input  logic rst_n,
  lbs_in_if.sink    in_ch,
  lbs_out_if.source out_ch
);

  localparam int unsigned BW = (BONES > 1) ? $clog2(BONES) : 1;
  localparam int unsigned DEPTH = BONES * lbs_pkg::ELEMS;

  logic adv;
  logic in_acc;

  // Palette memory, one lane per matrix element.
  logic [31:0] mem [lbs_pkg::ELEMS][BONES];

  logic [lbs_pkg::DIV12_SHIFT+lbs_pkg::SLOT_BONE_W-1:0] slot_mul;
  logic [lbs_pkg::SLOT_BONE_W-1:0] wr_bone;
  logic [lbs_pkg::SLOT_W-1:0] wr_elem;
  logic wr_en;

  // Sequencer stage.
  logic        busy_r;
  logic [1:0]  k_r;
  logic [1:0]  cnt_r;
  logic [15:0] idx_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [23:0] ids_r;
  logic [63:0] wgts_r;
  logic        last_bone;
  logic [lbs_pkg::ID_W-1:0] cur_id;
  logic        id_ok;

  // Stage 1: read data.
  logic        v1_r;
  lbs_pkg::lbs_tag_t tag1_r;
  logic        zero1_r;
  logic [31:0] rd_r [lbs_pkg::ELEMS];
  logic signed [31:0] pos1_r [lbs_pkg::COLS];
  logic signed [31:0] mat [lbs_pkg::ELEMS];

  // Stage 2: products.
  logic        v2_r;
  lbs_pkg::lbs_tag_t tag2_r;
  logic signed [63:0] prod_r [lbs_pkg::ROWS][lbs_pkg::COLS];
  logic signed [31:0] trans_r [lbs_pkg::ROWS];

  // Stage 3: row sums.
  logic        v3_r;
  lbs_pkg::lbs_tag_t tag3_r;
  logic signed [lbs_pkg::ROW_W-1:0] s_r [lbs_pkg::ROWS];
  logic signed [66:0] wprod [lbs_pkg::ROWS];

  // Stage 4: weighted terms.
  logic        v4_r;
  lbs_pkg::lbs_tag_t tag4_r;
  logic signed [lbs_pkg::TERM_W-1:0] term_r [lbs_pkg::ROWS];
  logic signed [lbs_pkg::ACC_W-1:0] acc_r [lbs_pkg::ROWS];
  logic signed [lbs_pkg::ACC_W-1:0] acc_sum [lbs_pkg::ROWS];
  logic signed [31:0] sat_val [lbs_pkg::ROWS];
  logic [lbs_pkg::ROWS-1:0] sat_bit;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_index_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic        out_sat_r;

  assign adv       = !out_valid_r || out_ch.ready;
  assign last_bone = (k_r == cnt_r);
  assign in_ch.ready = adv && (!busy_r || last_bone);
  assign in_acc    = in_ch.valid && in_ch.ready;

  assign slot_mul = (lbs_pkg::DIV12_SHIFT + lbs_pkg::SLOT_BONE_W)'(in_ch.matrix_slot)
                    * (lbs_pkg::DIV12_SHIFT + lbs_pkg::SLOT_BONE_W)'(lbs_pkg::DIV12_MUL);
  assign wr_bone  = slot_mul[lbs_pkg::DIV12_SHIFT +: lbs_pkg::SLOT_BONE_W];
  assign wr_elem  = in_ch.matrix_slot
                    - lbs_pkg::SLOT_W'(wr_bone) * lbs_pkg::SLOT_W'(lbs_pkg::ELEMS);
  assign wr_en    = in_acc && (in_ch.cmd == lbs_pkg::CMD_LOAD)
                    && (32'(in_ch.matrix_slot) < 32'(DEPTH));

  assign cur_id = ids_r[k_r*lbs_pkg::ID_W +: lbs_pkg::ID_W];
  assign id_ok  = 32'(cur_id) < 32'(BONES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int e = 0; e < lbs_pkg::ELEMS; e++) begin
        if (wr_elem == lbs_pkg::SLOT_W'(e)) begin
          mem[e][wr_bone[BW-1:0]] <= in_ch.matrix_value;
        end
      end
    end
    if (adv) begin
      for (int e = 0; e < lbs_pkg::ELEMS; e++) begin
        rd_r[e] <= mem[e][BW'(cur_id)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 2'd0;
    end else if (adv) begin
      if (in_acc && in_ch.cmd == lbs_pkg::CMD_SKIN) begin
        busy_r <= 1'b1;
        k_r    <= 2'd0;
      end else if (busy_r && last_bone) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.cmd == lbs_pkg::CMD_SKIN) begin
      cnt_r  <= in_ch.influence_count;
      idx_r  <= in_ch.vertex_index;
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
      pz_r   <= in_ch.pos_z;
      ids_r  <= in_ch.bone_ids;
      wgts_r <= in_ch.bone_weights;
    end
  end

  always_comb begin
    for (int e = 0; e < lbs_pkg::ELEMS; e++) begin
      mat[e] = zero1_r ? 32'sd0 : $signed(rd_r[e]);
    end
    for (int r = 0; r < lbs_pkg::ROWS; r++) begin
      wprod[r] = s_r[r] * $signed({1'b0, tag3_r.weight});
    end
    for (int r = 0; r < lbs_pkg::ROWS; r++) begin
      acc_sum[r] = tag4_r.first ? lbs_pkg::ACC_W'(term_r[r])
                                : acc_r[r] + lbs_pkg::ACC_W'(term_r[r]);
      if (acc_sum[r] > 54'sd2147483647) begin
        sat_val[r] = 32'sh7fffffff;
        sat_bit[r] = 1'b1;
      end else if (acc_sum[r] < -54'sd2147483648) begin
        sat_val[r] = 32'sh80000000;
        sat_bit[r] = 1'b1;
      end else begin
        sat_val[r] = acc_sum[r][31:0];
        sat_bit[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r.first  <= (k_r == 2'd0);
      tag1_r.last   <= last_bone;
      tag1_r.single <= (cnt_r == 2'd0);
      tag1_r.index  <= idx_r;
      tag1_r.weight <= wgts_r[k_r*lbs_pkg::WGT_W +: lbs_pkg::WGT_W];
      zero1_r       <= !id_ok;
      pos1_r[0]     <= px_r;
      pos1_r[1]     <= py_r;
      pos1_r[2]     <= pz_r;

      tag2_r <= tag1_r;
      for (int r = 0; r < lbs_pkg::ROWS; r++) begin
        for (int c = 0; c < lbs_pkg::COLS; c++) begin
          prod_r[r][c] <= mat[r*4+c] * pos1_r[c];
        end
        trans_r[r] <= mat[r*4+3];
      end

      tag3_r <= tag2_r;
      for (int r = 0; r < lbs_pkg::ROWS; r++) begin
        s_r[r] <= lbs_pkg::ROW_W'(trans_r[r])
                  + lbs_pkg::ROW_W'(prod_r[r][0] >>> 16)
                  + lbs_pkg::ROW_W'(prod_r[r][1] >>> 16)
                  + lbs_pkg::ROW_W'(prod_r[r][2] >>> 16);
      end

      tag4_r <= tag3_r;
      for (int r = 0; r < lbs_pkg::ROWS; r++) begin
        term_r[r] <= tag3_r.single ? lbs_pkg::TERM_W'(s_r[r])
                                   : lbs_pkg::TERM_W'(wprod[r] >>> 15);
      end

      if (v4_r) begin
        for (int r = 0; r < lbs_pkg::ROWS; r++) begin
          acc_r[r] <= acc_sum[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_r && tag4_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4_r && tag4_r.last) begin
      out_index_r <= tag4_r.index;
      out_x_r     <= sat_val[0];
      out_y_r     <= sat_val[1];
      out_z_r     <= sat_val[2];
      out_sat_r   <= |sat_bit;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_index_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_z     = out_z_r;
  assign out_ch.saturated = out_sat_r;

  a_ready_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> adv)
    else $error("input ready while pipeline is stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r <= cnt_r))
    else $error("bone counter passed influence count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !adv) |=> ($stable(k_r) && busy_r))
    else $error("sequencer moved during output stall");

  a_last_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v4_r && tag4_r.last) |=> out_valid_r)
    else $error("last bone of a vertex produced no result");

endmodule

>>> test/tb_linear_blend_skinning.sv
// Self-checking testbench for the linear blend skinning engine: it loads bone matrices,
// skins vertices, and compares every result word against an internal predictor.
// Depends on lbs_pkg, the channel interfaces in lbs_if and the linear_blend_skinning top.
module tb_linear_blend_skinning;

  localparam int unsigned NBONES = 64;
  localparam int unsigned DEPTH  = NBONES * lbs_pkg::ELEMS;
  localparam int unsigned IDLE_LIMIT = 3000;

  typedef struct {
    logic        cmd;
    logic [9:0]  slot;
    logic [31:0] value;
    logic [15:0] index;
    logic [31:0] px, py, pz;
    logic [1:0]  count;
    logic [23:0] ids;
    logic [63:0] weights;
  } lbs_word_t;

  typedef struct {
    logic [15:0] index;
    logic [31:0] x, y, z;
    logic        sat;
  } skin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lbs_in_if  in_ch();
  lbs_out_if out_ch();

  linear_blend_skinning #(.BONES(NBONES)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  lbs_word_t    send_queue[$];
  skin_result_t expected_results[$];
  logic [31:0]  palette_copy[DEPTH];
  bit           slot_written[DEPTH];
  int unsigned  loaded_bones[$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  int unsigned  idle_cycles = 0;
  bit           burst_mode = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  take_gap = 0;
  int unsigned  long_hold = 0;
  bit           long_hold_done = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void queue_load(int unsigned slot, logic [31:0] value);
    lbs_word_t w;
    int unsigned bone;
    bit full;
    w = '{default: '0};
    w.cmd = lbs_pkg::CMD_LOAD;
    w.slot = slot[9:0];
    w.value = value;
    w.index = 16'($urandom);
    w.ids = 24'($urandom);
    w.weights = {$urandom, $urandom};
    send_queue.push_back(w);
    if (slot < DEPTH) begin
      slot_written[slot] = 1'b1;
      bone = slot / lbs_pkg::ELEMS;
      full = 1'b1;
      for (int e = 0; e < lbs_pkg::ELEMS; e++) full &= slot_written[bone * lbs_pkg::ELEMS + e];
      if (full && !(bone inside {loaded_bones})) loaded_bones.push_back(bone);
    end
  endfunction

  function automatic void queue_bone(int unsigned bone, int mode);
    logic [31:0] v;
    for (int e = 0; e < lbs_pkg::ELEMS; e++) begin
      case (mode)
        0: v = (e % 4 == e / 4) ? 32'h0001_0000 : 32'h0;
        1: v = $urandom;
        2: v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: v = 32'($signed($urandom_range(0, 262144)) - 131072);
      endcase
      queue_load(bone * lbs_pkg::ELEMS + e, v);
    end
  endfunction

  function automatic logic [31:0] pick_coord(bit wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 8388608)) - 4194304);
  endfunction

  function automatic void queue_vertex(logic [1:0] count, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz, logic [63:0] weights,
                                       int unsigned forced_bone);
    lbs_word_t w;
    w.cmd = lbs_pkg::CMD_SKIN;
    w.slot = 10'($urandom);
    w.value = $urandom;
    w.index = 16'($urandom);
    w.px = px;
    w.py = py;
    w.pz = pz;
    w.count = count;
    w.ids = 24'($urandom);
    w.weights = weights;
    for (int k = 0; k <= count; k++) begin
      if (forced_bone < NBONES) w.ids[6*k +: 6] = forced_bone[5:0];
      else w.ids[6*k +: 6] = loaded_bones[$urandom_range(0, loaded_bones.size() - 1)];
    end
    send_queue.push_back(w);
  endfunction

  function automatic void skin_predict(lbs_word_t w);
    skin_result_t r;
    logic signed [127:0] acc, term, wv;
    longint row, m, p[3];
    int unsigned bone;
    p[0] = longint'($signed(w.px));
    p[1] = longint'($signed(w.py));
    p[2] = longint'($signed(w.pz));
    r.index = w.index;
    r.sat = 1'b0;
    for (int rr = 0; rr < lbs_pkg::ROWS; rr++) begin
      acc = '0;
      for (int k = 0; k <= w.count; k++) begin
        bone = w.ids[6*k +: 6];
        row = longint'($signed(palette_copy[bone * lbs_pkg::ELEMS + rr * 4 + 3]));
        for (int c = 0; c < lbs_pkg::COLS; c++) begin
          m = longint'($signed(palette_copy[bone * lbs_pkg::ELEMS + rr * 4 + c]));
          row += (m * p[c]) >>> 16;
        end
        if (w.count == 2'd0) begin
          acc = row;
        end else begin
          term = row;
          wv = w.weights[16*k +: 16];
          term = (term * wv) >>> 15;
          acc += term;
        end
      end
      if (acc > 128'sd2147483647) begin
        acc = 128'sd2147483647;
        r.sat = 1'b1;
      end else if (acc < -128'sd2147483648) begin
        acc = -128'sd2147483648;
        r.sat = 1'b1;
      end
      case (rr)
        0: r.x = acc[31:0];
        1: r.y = acc[31:0];
        default: r.z = acc[31:0];
      endcase
    end
    expected_results.push_back(r);
  endfunction

  // Input side: apply each accepted word to the predictor.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.cmd == lbs_pkg::CMD_LOAD) begin
        if (in_ch.matrix_slot < DEPTH) palette_copy[in_ch.matrix_slot] = in_ch.matrix_value;
      end else begin
        skin_predict('{in_ch.cmd, in_ch.matrix_slot, in_ch.matrix_value, in_ch.vertex_index,
                       in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.influence_count,
                       in_ch.bone_ids, in_ch.bone_weights});
      end
    end
  end

  // Driver.
  always @(posedge clk) begin
    lbs_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (send_queue.size() > 0) begin
        w = send_queue.pop_front();
        in_ch.cmd <= w.cmd;
        in_ch.matrix_slot <= w.slot;
        in_ch.matrix_value <= w.value;
        in_ch.vertex_index <= w.index;
        in_ch.pos_x <= w.px;
        in_ch.pos_y <= w.py;
        in_ch.pos_z <= w.pz;
        in_ch.influence_count <= w.count;
        in_ch.bone_ids <= w.ids;
        in_ch.bone_weights <= w.weights;
        in_ch.valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) burst_mode = ~burst_mode;
        send_gap = burst_mode ? 0 : $urandom_range(0, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted here while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (long_hold > 0) begin
        long_hold--;
      end else if (results_seen >= 300 && !long_hold_done) begin
        long_hold = 400;
        long_hold_done = 1'b1;
      end
    end
  end

  // Monitor and result checker.
  always @(posedge clk) begin
    skin_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word index=%h", $realtime, out_ch.out_index);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.out_index !== e.index) begin
            $display("%0t: index expected %h actual %h", $realtime, e.index, out_ch.out_index);
            errors++;
          end
          if (out_ch.out_x !== e.x) begin
            $display("%0t: x expected %h actual %h", $realtime, e.x, out_ch.out_x);
            errors++;
          end
          if (out_ch.out_y !== e.y) begin
            $display("%0t: y expected %h actual %h", $realtime, e.y, out_ch.out_y);
            errors++;
          end
          if (out_ch.out_z !== e.z) begin
            $display("%0t: z expected %h actual %h", $realtime, e.z, out_ch.out_z);
            errors++;
          end
          if (out_ch.saturated !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $realtime, e.sat,
                     out_ch.saturated);
            errors++;
          end
        end
        take_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned dice;
    in_ch.valid = 1'b0;
    in_ch.cmd = lbs_pkg::CMD_LOAD;
    in_ch.matrix_slot = '0;
    in_ch.matrix_value = '0;
    in_ch.vertex_index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.influence_count = '0;
    in_ch.bone_ids = '0;
    in_ch.bone_weights = '0;
    out_ch.ready = 1'b0;

    // Directed part: identity bone, extreme bone, loads past the palette, extreme positions and weights.
    queue_bone(0, 0);
    queue_bone(NBONES - 1, 2);
    queue_load(DEPTH, 32'hFFFF_FFFF);
    queue_load(1023, 32'h1234_5678);
    queue_vertex(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 64'h0, 0);
    queue_vertex(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'h0, NBONES - 1);
    queue_vertex(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 NBONES - 1);
    queue_vertex(2'd1, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 64'h0000_0000_8000_0000, 0);
    queue_vertex(2'd3, 32'h0, 32'h0, 32'h0, 64'h0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (send_queue.size() < 1850) begin
      dice = $urandom_range(0, 99);
      if (dice < 12) begin
        queue_bone($urandom_range(0, NBONES - 1), $urandom_range(1, 3));
      end else if (dice < 15) begin
        queue_load($urandom_range(0, 1023), $urandom);
      end else begin
        queue_vertex(2'($urandom), pick_coord($urandom_range(0, 3) == 0),
                     pick_coord($urandom_range(0, 3) == 0),
                     pick_coord($urandom_range(0, 3) == 0), {$urandom, $urandom}, NBONES);
      end
    end

    while (send_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
